// ===== rtl/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// aoc_pkg
// shared types and constants of the source-over rgba8 compositor
// ----------------------------------------------------------------------------
package aoc_pkg;

   localparam int CHAN_NUM = 3;

   localparam logic [7:0]  FULL_SCALE   = 8'd255;
   // floor(x / 255) = (x * RECIP_255) >> SHIFT_255 for any 16-bit x
   localparam logic [15:0] RECIP_255    = 16'h8081;
   localparam int          SHIFT_255    = 23;
   // floor(n / 65025) = (n * RECIP_65025) >> SHIFT_65025 for n <= 255 * 65025
   localparam logic [24:0] RECIP_65025  = 25'd16909061;
   localparam int          SHIFT_65025  = 40;

   localparam logic [1:0] MODE_ZERO  = 2'd0;
   localparam logic [1:0] MODE_DST   = 2'd1;
   localparam logic [1:0] MODE_SRC   = 2'd2;
   localparam logic [1:0] MODE_BLEND = 2'd3;

   typedef struct packed {
      logic [7:0]                   alpha;
      logic [CHAN_NUM-1:0][7:0]     chan;
   } pixel_type;

   typedef struct packed {
      pixel_type src;
      pixel_type dst;
   } pair_type;

   typedef struct packed {
      pixel_type   src;
      pixel_type   dst;
      logic [1:0]  mode;
      logic [15:0] wa;
      logic [15:0] wd;
   } weight_type;

   typedef struct packed {
      pixel_type                src;
      pixel_type                dst;
      logic [1:0]               mode;
      logic [CHAN_NUM-1:0][23:0] num;
      logic [7:0]               alpha;
   } sum_type;

   typedef struct packed {
      pixel_type  src;
      pixel_type  dst;
      logic [1:0] mode;
      pixel_type  blend;
   } scaled_type;

endpackage

// ===== rtl/aoc_weight.sv =====
// ----------------------------------------------------------------------------
// aoc_weight
// stage one: case decode and the two blend weights as*255, (255-as)*ad
// ----------------------------------------------------------------------------
module aoc_weight import aoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  pair_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output weight_type out_data
);

   logic       valid_ff, valid_in;
   weight_type data_ff, data_in;
   logic [7:0] src_a, dst_a, inv_a;

   assign in_ready = !valid_ff || out_ready;
   assign src_a    = in_data.src.alpha;
   assign dst_a    = in_data.dst.alpha;
   assign inv_a    = FULL_SCALE - src_a;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         data_in.src = in_data.src;
         data_in.dst = in_data.dst;
         data_in.wa  = {src_a, 8'd0} - {8'd0, src_a};
         data_in.wd  = {8'd0, inv_a} * {8'd0, dst_a};
         priority if (src_a == 8'd0 && dst_a == 8'd0) begin
            data_in.mode = MODE_ZERO;
         end else if (src_a == 8'd0) begin
            data_in.mode = MODE_DST;
         end else if (dst_a == 8'd0) begin
            data_in.mode = MODE_SRC;
         end else begin
            data_in.mode = MODE_BLEND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/aoc_product.sv =====
// ----------------------------------------------------------------------------
// aoc_product
// stages two and three: weighted channel products, then numerator sums
// and the blended alpha
// ----------------------------------------------------------------------------
module aoc_product import aoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  weight_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output sum_type    out_data
);

   typedef struct packed {
      pixel_type                 src;
      pixel_type                 dst;
      logic [1:0]                mode;
      logic [CHAN_NUM-1:0][23:0] ps;
      logic [CHAN_NUM-1:0][23:0] pd;
      logic [31:0]               apm;
   } prod_type;

   logic     prod_valid_ff, prod_valid_in, prod_ready;
   prod_type prod_ff, prod_in;
   logic     sum_valid_ff, sum_valid_in;
   sum_type  sum_ff, sum_in;

   // product stage
   assign in_ready = !prod_valid_ff || prod_ready;

   always_comb begin
      prod_valid_in = prod_valid_ff;
      prod_in       = prod_ff;
      if (in_ready) begin
         prod_valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         prod_in.src  = in_data.src;
         prod_in.dst  = in_data.dst;
         prod_in.mode = in_data.mode;
         for (int k = 0; k < CHAN_NUM; k++) begin
            prod_in.ps[k] = 24'(in_data.src.chan[k]) * 24'(in_data.wa);
            prod_in.pd[k] = 24'(in_data.dst.chan[k]) * 24'(in_data.wd);
         end
         prod_in.apm = 32'(in_data.wd) * 32'(RECIP_255);
      end
   end

   // sum stage
   assign prod_ready = !sum_valid_ff || out_ready;

   always_comb begin
      sum_valid_in = sum_valid_ff;
      sum_in       = sum_ff;
      if (prod_ready) begin
         sum_valid_in = prod_valid_ff;
      end
      if (prod_ready && prod_valid_ff) begin
         sum_in.src  = prod_ff.src;
         sum_in.dst  = prod_ff.dst;
         sum_in.mode = prod_ff.mode;
         for (int k = 0; k < CHAN_NUM; k++) begin
            sum_in.num[k] = prod_ff.ps[k] + prod_ff.pd[k];
         end
         sum_in.alpha = prod_ff.src.alpha + prod_ff.apm[SHIFT_255 +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         sum_valid_ff  <= sum_valid_in;
      end
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   assign out_valid = sum_valid_ff;
   assign out_data  = sum_ff;

   // blended alpha never wraps below the source alpha
   a_alpha_no_wrap : assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && sum_ff.mode == MODE_BLEND |-> sum_ff.alpha >= sum_ff.src.alpha)
      else $error("blended alpha wrapped");

   // numerator stays within 255 * 65025
   a_num_range : assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff |-> sum_ff.num[0] <= 24'd16581375 && sum_ff.num[1] <= 24'd16581375
                       && sum_ff.num[2] <= 24'd16581375)
      else $error("numerator out of range");

   // a stalled product stage keeps its item
   a_prod_hold : assert property (@(posedge clock) disable iff (reset)
      prod_valid_ff && !prod_ready |=> prod_valid_ff && $stable(prod_ff))
      else $error("product stage lost an item under stall");

endmodule

// ===== rtl/aoc_scale.sv =====
// ----------------------------------------------------------------------------
// aoc_scale
// stages four and five: reciprocal scaling by 1/65025, then case select
// into the output register
// ----------------------------------------------------------------------------
module aoc_scale import aoc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  sum_type    in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output pixel_type  out_data
);

   logic       scl_valid_ff, scl_valid_in, scl_ready;
   scaled_type scl_ff, scl_in;
   logic       out_valid_ff, out_valid_in;
   pixel_type  out_ff, out_in;
   logic [CHAN_NUM-1:0][48:0] prod;

   // scaling stage
   assign in_ready = !scl_valid_ff || scl_ready;

   always_comb begin
      for (int k = 0; k < CHAN_NUM; k++) begin
         prod[k] = 49'(in_data.num[k]) * 49'(RECIP_65025);
      end
   end

   always_comb begin
      scl_valid_in = scl_valid_ff;
      scl_in       = scl_ff;
      if (in_ready) begin
         scl_valid_in = in_valid;
      end
      if (in_ready && in_valid) begin
         scl_in.src         = in_data.src;
         scl_in.dst         = in_data.dst;
         scl_in.mode        = in_data.mode;
         scl_in.blend.alpha = in_data.alpha;
         for (int k = 0; k < CHAN_NUM; k++) begin
            scl_in.blend.chan[k] = prod[k][SHIFT_65025 +: 8];
         end
      end
   end

   // output register
   assign scl_ready = !out_valid_ff || out_ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (scl_ready) begin
         out_valid_in = scl_valid_ff;
      end
      if (scl_ready && scl_valid_ff) begin
         unique case (scl_ff.mode)
            MODE_ZERO:  out_in = '0;
            MODE_DST:   out_in = scl_ff.dst;
            MODE_SRC:   out_in = scl_ff.src;
            MODE_BLEND: out_in = scl_ff.blend;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         scl_valid_ff <= scl_valid_in;
         out_valid_ff <= out_valid_in;
      end
      scl_ff <= scl_in;
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // scaled red channel never exceeds the larger of the two input red channels
   a_blend_bound : assert property (@(posedge clock) disable iff (reset)
      scl_valid_ff && scl_ff.mode == MODE_BLEND |->
         (scl_ff.blend.chan[0] <= scl_ff.src.chan[0] ||
          scl_ff.blend.chan[0] <= scl_ff.dst.chan[0]))
      else $error("blended red above both inputs");

   // a transparent pair leaves all zeros
   a_zero_pair : assert property (@(posedge clock) disable iff (reset)
      scl_valid_ff && scl_ready && scl_ff.mode == MODE_ZERO |=> out_ff == '0)
      else $error("transparent pair not cleared");

   // a stalled scaling stage keeps its item
   a_scl_hold : assert property (@(posedge clock) disable iff (reset)
      scl_valid_ff && !scl_ready |=> scl_valid_ff && $stable(scl_ff))
      else $error("scaling stage lost an item under stall");

endmodule

// ===== rtl/alpha_over_composite_rgba8.sv =====
// ----------------------------------------------------------------------------
// alpha_over_composite_rgba8
// source-over-destination compositing of one rgba8 pixel pair per transfer
//
//   channel  dir  tdata                           tuser  tlast
//   req_     in   64 bit, src rgba then dst rgba  -      -
//   rsp_     out  32 bit, composited rgba         -      -
//
// one pixel pair accepted every cycle while rsp_tready does not stall the pipeline
// five register stages: weights, products, sums, 1/65025 scaling, output
// each stage frees itself when its successor takes its item, so bubbles close
// under back-pressure and a stall holds every item in place
// synchronous reset clears the stage valid bits only
// ----------------------------------------------------------------------------
module alpha_over_composite_rgba8 import aoc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata
);

   pair_type   pair;
   logic       w_valid, w_ready;
   weight_type w_data;
   logic       s_valid, s_ready;
   sum_type    s_data;
   pixel_type  result;

   assign pair.src.chan[0] = req_tdata[7:0];
   assign pair.src.chan[1] = req_tdata[15:8];
   assign pair.src.chan[2] = req_tdata[23:16];
   assign pair.src.alpha   = req_tdata[31:24];
   assign pair.dst.chan[0] = req_tdata[39:32];
   assign pair.dst.chan[1] = req_tdata[47:40];
   assign pair.dst.chan[2] = req_tdata[55:48];
   assign pair.dst.alpha   = req_tdata[63:56];

   aoc_weight u_weight (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pair),
      .out_valid (w_valid),
      .out_ready (w_ready),
      .out_data  (w_data)
   );

   aoc_product u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (w_valid),
      .in_ready  (w_ready),
      .in_data   (w_data),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_data  (s_data)
   );

   aoc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_data   (s_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (result)
   );

   assign rsp_tdata = {result.alpha, result.chan[2], result.chan[1], result.chan[0]};

endmodule
